// ===== hdl/sha256_pkg.sv =====
package sha256_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned Rounds = 64;

  localparam logic [7:0] PadByte = 8'h80;

  typedef logic [31:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
    word_t f;
    word_t g;
    word_t h;
  } vars_t;

  localparam vars_t InitHash = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic word_t round_k(input logic [5:0] t);
    word_t k;
    case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
      6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
      6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
      6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
      6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_PAD   = 6'b000010,
    ST_ROUND = 6'b000100,
    ST_ADD   = 6'b001000,
    ST_LEN   = 6'b010000,
    ST_OUT   = 6'b100000
  } state_t;

endpackage

// ===== hdl/sha256_round.sv =====
module sha256_round (
  input  sha256_pkg::vars_t v,
  input  sha256_pkg::word_t wt,
  input  sha256_pkg::word_t kt,
  output sha256_pkg::vars_t v_next
);
  sha256_pkg::word_t s1;
  sha256_pkg::word_t s0;
  sha256_pkg::word_t ch;
  sha256_pkg::word_t maj;
  sha256_pkg::word_t t1;
  sha256_pkg::word_t t2;

  always_comb begin
    s1 = {v.e[5:0], v.e[31:6]} ^ {v.e[10:0], v.e[31:11]} ^ {v.e[24:0], v.e[31:25]};
    s0 = {v.a[1:0], v.a[31:2]} ^ {v.a[12:0], v.a[31:13]} ^ {v.a[21:0], v.a[31:22]};
    ch = (v.e & v.f) ^ (~v.e & v.g);
    maj = (v.a & v.b) ^ (v.a & v.c) ^ (v.b & v.c);
    t1 = v.h + s1 + ch + kt + wt;
    t2 = s0 + maj;
    v_next = '{t1 + t2, v.a, v.b, v.c, v.d + t1, v.e, v.f, v.g};
  end
endmodule

// ===== hdl/sha256_stream_hasher_unit.sv =====
// SHA-256 hasher. Each accepted item carries at most one message byte; bytes are packed into a
// 16-word schedule window. The 64th byte of a block starts a compression of 64 rounds followed
// by the hash update, and ready stays low until both are done. An item with message_end writes
// the pad byte and the zero fill at one byte position per cycle up to the length field, writes
// the length, runs each of its one or two compressions, then presents the eight digest words,
// word 0 first, one per accepted output cycle. The single round unit runs one round per cycle.
module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        has_byte,
  input  logic        message_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  sha256_pkg::state_t state;
  sha256_pkg::vars_t  hash;
  sha256_pkg::vars_t  v;
  sha256_pkg::vars_t  v_next;
  sha256_pkg::word_t  win [16];
  sha256_pkg::word_t  wt;
  sha256_pkg::word_t  w15;
  sha256_pkg::word_t  w2;
  sha256_pkg::word_t  wnew;
  logic [63:0] bits;
  logic [63:0] msg_len;
  logic [5:0]  pos;
  logic [5:0]  rnd;
  logic        pending_end;
  logic        padding;
  logic        len_done;
  logic [2:0]  oidx;
  logic [3:0]  slot;
  logic [7:0]  pbyte;

  assign pos = bits[8:3];
  assign in_ready = (state == sha256_pkg::ST_IDLE);
  assign out_valid = (state == sha256_pkg::ST_OUT);
  assign word_index = oidx;
  assign last_word = (oidx == 3'd7);

  always_comb begin
    case (oidx)
      3'd0: digest_word = hash.a;
      3'd1: digest_word = hash.b;
      3'd2: digest_word = hash.c;
      3'd3: digest_word = hash.d;
      3'd4: digest_word = hash.e;
      3'd5: digest_word = hash.f;
      3'd6: digest_word = hash.g;
      default: digest_word = hash.h;
    endcase
  end

  // schedule: window slot 0 always holds W[t]; the window shifts each round
  always_comb begin
    w15 = win[1];
    w2 = win[14];
    wnew = win[0] + win[9]
         + ({w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3))
         + ({w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10));
    wt = win[0];
  end

  sha256_round u_round (
    .v      (v),
    .wt     (wt),
    .kt     (sha256_pkg::round_k(rnd)),
    .v_next (v_next)
  );

  always_comb begin
    slot = pos[5:2];
    pbyte = (state == sha256_pkg::ST_IDLE) ? data_byte
          : (pending_end ? sha256_pkg::PadByte : 8'h00);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sha256_pkg::ST_IDLE;
      hash <= sha256_pkg::InitHash;
      bits <= '0;
      rnd <= '0;
      pending_end <= 1'b0;
      padding <= 1'b0;
      len_done <= 1'b0;
      oidx <= '0;
    end else begin
      case (state)
        sha256_pkg::ST_IDLE: begin
          if (in_valid) begin
            pending_end <= message_end;
            len_done <= 1'b0;
            if (message_end) begin
              padding <= 1'b1;
              msg_len <= bits + (has_byte ? 64'd8 : 64'd0);
            end
            if (has_byte) begin
              case (pos[1:0])
                2'd0: win[slot][31:24] <= data_byte;
                2'd1: win[slot][23:16] <= data_byte;
                2'd2: win[slot][15:8]  <= data_byte;
                default: win[slot][7:0] <= data_byte;
              endcase
              bits <= bits + 64'd8;
              if (pos == 6'd63) begin
                v <= hash;
                rnd <= '0;
                state <= sha256_pkg::ST_ROUND;
              end else if (message_end) begin
                state <= sha256_pkg::ST_PAD;
              end
            end else if (message_end) begin
              state <= sha256_pkg::ST_PAD;
            end
          end
        end
        // write pad byte, then zeros, using bits as the byte cursor
        sha256_pkg::ST_PAD: begin
          case (pos[1:0])
            2'd0: win[slot][31:24] <= pbyte;
            2'd1: win[slot][23:16] <= pbyte;
            2'd2: win[slot][15:8]  <= pbyte;
            default: win[slot][7:0] <= pbyte;
          endcase
          pending_end <= 1'b0;
          bits <= bits + 64'd8;
          rnd <= '0;
          if (pos == 6'd63) begin
            v <= hash;
            state <= sha256_pkg::ST_ROUND;
          end else if (pos == 6'd55 && !len_done) begin
            state <= sha256_pkg::ST_LEN;
          end
        end
        sha256_pkg::ST_LEN: begin
          // length goes into words 14 and 15 from the count saved at message end
          win[14] <= msg_len[63:32];
          win[15] <= msg_len[31:0];
          len_done <= 1'b1;
          v <= hash;
          rnd <= '0;
          state <= sha256_pkg::ST_ROUND;
        end
        sha256_pkg::ST_ROUND: begin
          v <= v_next;
          for (int i = 0; i < 15; i++) win[i] <= win[i + 1];
          win[15] <= wnew;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) state <= sha256_pkg::ST_ADD;
        end
        sha256_pkg::ST_ADD: begin
          hash <= '{hash.a + v.a, hash.b + v.b, hash.c + v.c, hash.d + v.d,
                    hash.e + v.e, hash.f + v.f, hash.g + v.g, hash.h + v.h};
          if (len_done) begin
            oidx <= '0;
            state <= sha256_pkg::ST_OUT;
          end else if (padding) begin
            state <= sha256_pkg::ST_PAD;
          end else begin
            state <= sha256_pkg::ST_IDLE;
          end
        end
        sha256_pkg::ST_OUT: begin
          if (out_ready) begin
            oidx <= oidx + 3'd1;
            if (oidx == 3'd7) begin
              hash <= sha256_pkg::InitHash;
              bits <= '0;
              padding <= 1'b0;
              state <= sha256_pkg::ST_IDLE;
            end
          end
        end
        default: state <= sha256_pkg::ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !out_valid) else $error("ready while presenting digest");
  a_round_count: assert property (@(posedge clk) disable iff (rst)
    (state == sha256_pkg::ST_ROUND && rnd == 6'd63) |=> state == sha256_pkg::ST_ADD)
    else $error("round sequencer overran");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> out_valid && $stable(oidx))
    else $error("digest word dropped");
`endif
endmodule

// ===== verif/tb_sha256_stream_hasher_unit.sv =====
module tb_sha256_stream_hasher_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WatchLimit = 20000;

  typedef struct {
    sha256_pkg::word_t digest_word;
    logic [2:0]        word_index;
    logic              last_word;
  } digest_out_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        has_byte = 1'b0;
  logic        message_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  // running hash state of the predictor
  sha256_pkg::word_t hash_h[8];
  logic [7:0]  msg_block[64];
  logic [63:0] msg_bits;
  digest_out_t digest_q[$];

  int  errors = 0;
  int  items_sent = 0;
  int  words_seen = 0;
  int  idle_cnt = 0;
  int  hold_off = 0;
  bit  hold_req = 1'b0;
  bit  hold_done = 1'b0;

  sha256_stream_hasher_unit dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic sha256_pkg::word_t rotr(sha256_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress();
    sha256_pkg::word_t w[16];
    sha256_pkg::word_t v[8];
    sha256_pkg::word_t s0, s1, t1, t2, wt;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int j = 0; j < 8; j++) v[j] = hash_h[j];
    for (int t = 0; t < 64; t++) begin
      if (t >= 16) begin
        s0 = rotr(w[(t-15)&15], 7) ^ rotr(w[(t-15)&15], 18) ^ (w[(t-15)&15] >> 3);
        s1 = rotr(w[(t-2)&15], 17) ^ rotr(w[(t-2)&15], 19) ^ (w[(t-2)&15] >> 10);
        w[t&15] = w[t&15] + s0 + w[(t-7)&15] + s1;
      end
      wt = w[t&15];
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::round_k(t[5:0]) + wt;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_h[j] += v[j];
  endfunction

  function automatic void reset_hash();
    sha256_pkg::vars_t iv;
    iv = sha256_pkg::InitHash;
    hash_h = '{iv.a, iv.b, iv.c, iv.d, iv.e, iv.f, iv.g, iv.h};
    msg_bits = '0;
  endfunction

  function automatic void predict_item(logic [7:0] b, logic hb, logic me);
    int pos;
    digest_out_t d;
    if (hb) begin
      pos = int'(msg_bits[8:3]);
      msg_block[pos] = b;
      msg_bits += 64'd8;
      if (pos == 63) compress();
    end
    if (!me) return;
    pos = int'(msg_bits[8:3]);
    msg_block[pos] = sha256_pkg::PadByte;
    for (int j = pos + 1; j < 64; j++) msg_block[j] = '0;
    if (pos >= 56) begin
      compress();
      for (int j = 0; j < 64; j++) msg_block[j] = '0;
    end
    for (int j = 0; j < 8; j++) msg_block[56+j] = msg_bits[63-8*j -: 8];
    compress();
    for (int j = 0; j < 8; j++) begin
      d.digest_word = hash_h[j];
      d.word_index = j[2:0];
      d.last_word = (j == 7);
      digest_q.push_back(d);
    end
    reset_hash();
  endfunction

  // valid stays up after an accept; drop it only when a gap follows
  task automatic send_item(logic [7:0] b, logic hb, logic me);
    int gap;
    gap = int'($urandom_range(0, 6));
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    has_byte <= hb;
    message_end <= me;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(b, hb, me);
    items_sent++;
  endtask

  task automatic send_message(int len, bit end_with_byte);
    for (int i = 0; i < len; i++)
      send_item(8'($urandom_range(0, 255)), 1'b1, end_with_byte && (i == len - 1));
    if (!end_with_byte || len == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // empty message, idle items, byte extremes
  task automatic test_directed();
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'haa, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b1);
    wait_drained();
  endtask

  task automatic test_pad_lengths();
    int lens[3] = '{55, 56, 64};
    foreach (lens[i]) send_message(lens[i], 1'($urandom_range(0, 1)));
    wait_drained();
  endtask

  task automatic test_random_messages();
    int n;
    n = 0;
    while (items_sent < 200) begin
      case ($urandom_range(0, 9))
        0: n = int'($urandom_range(56, 70));
        1: send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        default: n = int'($urandom_range(0, 20));
      endcase
      send_message(n, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 4) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end
    wait_drained();
  endtask

  // receiver stalls while several short messages queue up behind it
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int m = 0; m < 4; m++) send_message(int'($urandom_range(0, 3)), 1'b1);
    wait_drained();
  endtask

  initial begin
    reset_hash();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_pad_lengths();
    test_backpressure();
    test_random_messages();
    repeat (100) @(posedge clk);
    $display("Sent %0d items, checked %0d digest words, including pad-boundary lengths",
             items_sent, words_seen);
    $display("and a long output stall.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver: random stalls, with one long hold when requested
  always @(posedge clk) begin
    int w;
    if (rst) begin
      out_ready <= 1'b0;
      idle_cnt <= 0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_off <= 400;
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (out_valid && out_ready) begin
      w = $urandom_range(0, 1) ? 0 : int'($urandom_range(0, 6));
      idle_cnt <= w;
      out_ready <= (w == 0);
    end else if (idle_cnt > 0) begin
      idle_cnt <= idle_cnt - 1;
      out_ready <= (idle_cnt == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    digest_out_t e;
    if (!rst && out_valid && out_ready) begin
      words_seen++;
      if (digest_q.size() == 0) begin
        $error("digest word with nothing expected: %h", digest_word);
        errors++;
      end else begin
        e = digest_q.pop_front();
        if (digest_word !== e.digest_word) begin
          $error("digest_word expected %h actual %h", e.digest_word, digest_word);
          errors++;
        end
        if (word_index !== e.word_index) begin
          $error("word_index expected %0d actual %0d", e.word_index, word_index);
          errors++;
        end
        if (last_word !== e.last_word) begin
          $error("last_word expected %0d actual %0d", e.last_word, last_word);
          errors++;
        end
      end
    end
  end

  int stuck = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck <= 0;
    end else if (stuck >= WatchLimit) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

endmodule
